// ----- hw/rtl/mtref_pkg.sv -----
// Package: shared constants, types and helpers for the multitouch region event filter.
package mtref_pkg;

	localparam int MaxFingers = 10;
	localparam int SlotW = 4;

	localparam logic [3:0] ACT_SLOT   = 4'd0;
	localparam logic [3:0] ACT_TRACK  = 4'd1;
	localparam logic [3:0] ACT_X      = 4'd2;
	localparam logic [3:0] ACT_Y      = 4'd3;
	localparam logic [3:0] ACT_MAJOR  = 4'd4;
	localparam logic [3:0] ACT_MINOR  = 4'd5;
	localparam logic [3:0] ACT_ORIENT = 4'd6;
	localparam logic [3:0] ACT_TOOL   = 4'd7;
	localparam logic [3:0] ACT_SYNC   = 4'd8;

	localparam logic [1:0] ST_DOWN = 2'd0;
	localparam logic [1:0] ST_MOVE = 2'd1;
	localparam logic [1:0] ST_UP   = 2'd2;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_LEFT   = 3'd1;
	localparam logic [2:0] REG_RIGHT  = 3'd2;
	localparam logic [2:0] REG_TOP    = 3'd3;
	localparam logic [2:0] REG_BOTTOM = 3'd4;
	localparam logic [2:0] REG_RADX   = 3'd5;
	localparam logic [2:0] REG_RADY   = 3'd6;

	localparam logic signed [31:0] PALM_TOOL = 32'sd2;
	localparam logic signed [17:0] ACC_MAX = 18'sd131071;
	localparam logic signed [17:0] ACC_MIN = -18'sd131072;

	// controller -> datapath
	typedef struct packed {
		logic event_en;  // apply input beat (non-sync)
		logic sync_start;
		logic slot_step; // evaluate slot slot_idx
		logic load_out;  // move pending report to output register
		logic [SlotW-1:0] slot_idx;
	} mtref_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit;      // slot step produced a result
	} mtref_sts_t;

	typedef struct packed {
		logic [3:0] slot_index;
		logic [1:0] touch_state;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [47:0] touch_down_us;
		logic [15:0] contact_major;
		logic [15:0] contact_minor;
		logic [15:0] contact_orientation;
		logic [3:0] finger_count;
		logic [47:0] frame_time_us;
	} mtref_res_t;

	function automatic logic [15:0] abs_sat16(input logic signed [31:0] v);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : 32'(v);
		return (v[31] && m[31]) || (m > 32'd65535) ? 16'hFFFF : m[15:0];
	endfunction

	function automatic logic [15:0] usat16(input logic signed [31:0] v);
		return v[31] ? 16'd0 : (v > 32'sd65535 ? 16'hFFFF : v[15:0]);
	endfunction

	function automatic logic [15:0] ssat16(input logic signed [31:0] v);
		return v > 32'sd32767 ? 16'h7FFF : (v < -32'sd32768 ? 16'h8000 : v[15:0]);
	endfunction

endpackage

// ----- hw/rtl/mtref_datapath.sv -----
// Datapath: slot records, region gating, radius filter and result register.
module mtref_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [3:0] action,
	input  logic signed [31:0] value,
	input  logic [47:0] timestamp_us,
	input  mtref_pkg::mtref_cmd_t cmd,
	output mtref_pkg::mtref_sts_t sts,
	output logic detect_en,
	output logic [mtref_pkg::MaxFingers-1:0] upd,
	output mtref_pkg::mtref_res_t res
);
	import mtref_pkg::*;

	logic [2:0] mode_q;
	logic [15:0] left_q, right_q, top_q, bottom_q, radx_q, rady_q;
	logic [SlotW:0] active_q; // MSB set means invalid
	logic [MaxFingers-1:0] has_q, upd_q, phas_q, inside_q;
	logic [31:0] tid_q [MaxFingers];
	logic [31:0] ptid_q [MaxFingers];
	logic [15:0] x_q [MaxFingers], y_q [MaxFingers], px_q [MaxFingers], py_q [MaxFingers];
	logic [15:0] maj_q [MaxFingers], min_q [MaxFingers], ori_q [MaxFingers];
	logic [47:0] dt_q [MaxFingers];
	logic signed [17:0] ax_q [MaxFingers], ay_q [MaxFingers];
	logic [3:0] count_q;
	logic [47:0] fts_q;
	mtref_res_t pnd_q;
	logic [16:0] hw_c, hh_c;
	logic small_in, large_in, has, pass, keep, cfg_hit;
	logic [1:0] st;
	logic [SlotW-1:0] s, as;
	logic signed [19:0] sx, sy;
	logic signed [17:0] nax, nay, dxa, dya;
	logic [3:0] cnt_c;

	assign detect_en = mode_q[0];
	assign upd = upd_q;
	assign cfg_hit = cfg_we && cfg_index <= REG_RADY;
	assign s = cmd.slot_idx;
	assign as = active_q[SlotW-1:0];
	assign hw_c = (right_q >= left_q) ? {1'b0, 16'(right_q - left_q) >> 1} : 17'd0;
	assign hh_c = (bottom_q >= top_q) ? {1'b0, 16'(bottom_q - top_q) >> 1} : 17'd0;

	always_comb begin
		cnt_c = '0;
		for (int k = 0; k < MaxFingers; k++) cnt_c = cnt_c + 4'(has_q[k]);
	end

	always_comb begin
		has = has_q[s];
		small_in = x_q[s] >= left_q && x_q[s] <= right_q && y_q[s] >= top_q && y_q[s] <= bottom_q;
		large_in = {1'b0, x_q[s]} + hw_c >= {1'b0, left_q}
			&& {1'b0, x_q[s]} <= {1'b0, right_q} + hw_c
			&& {1'b0, y_q[s]} + hh_c >= {1'b0, top_q}
			&& {1'b0, y_q[s]} <= {1'b0, bottom_q} + hh_c
			&& right_q >= left_q && bottom_q >= top_q;
		if (!has) st = ST_UP;
		else if (!phas_q[s] || ptid_q[s] != tid_q[s]) st = ST_DOWN;
		else st = ST_MOVE;
		keep = 1'b1;
		if (!inside_q[s]) begin
			if (small_in && has) st = ST_DOWN;
			else if (mode_q[1]) begin
				if (st == ST_DOWN) st = ST_MOVE;
			end else keep = 1'b0;
		end else if (has && !large_in) st = ST_UP;
		sx = 20'(ax_q[s]) + 20'({4'd0, x_q[s]}) - 20'({4'd0, px_q[s]});
		sy = 20'(ay_q[s]) + 20'({4'd0, y_q[s]}) - 20'({4'd0, py_q[s]});
		nax = sx > 20'(ACC_MAX) ? ACC_MAX : (sx < 20'(ACC_MIN) ? ACC_MIN : sx[17:0]);
		nay = sy > 20'(ACC_MAX) ? ACC_MAX : (sy < 20'(ACC_MIN) ? ACC_MIN : sy[17:0]);
		dxa = nax[17] ? -nax : nax;
		dya = nay[17] ? -nay : nay;
		pass = !mode_q[2] || 18'(dxa) > {2'b0, radx_q} || 18'(dya) > {2'b0, rady_q};
		if (st == ST_MOVE && !pass) keep = 1'b0;
	end
	assign sts.emit = keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; left_q <= '0; right_q <= '0; top_q <= '0; bottom_q <= '0;
			radx_q <= '0; rady_q <= '0;
			active_q <= '1;
			has_q <= '0; upd_q <= '0; phas_q <= '0; inside_q <= '0;
			count_q <= '0; fts_q <= '0;
			pnd_q <= '0; res <= '0;
			for (int k = 0; k < MaxFingers; k++) begin
				tid_q[k] <= '1; ptid_q[k] <= '1;
				x_q[k] <= '0; y_q[k] <= '0; px_q[k] <= '0; py_q[k] <= '0;
				maj_q[k] <= '0; min_q[k] <= '0; ori_q[k] <= '0; dt_q[k] <= '0;
				ax_q[k] <= '0; ay_q[k] <= '0;
			end
		end else begin
			if (cfg_hit) begin
				case (cfg_index)
					REG_MODE:   mode_q <= cfg_data[2:0];
					REG_LEFT:   left_q <= cfg_data;
					REG_RIGHT:  right_q <= cfg_data;
					REG_TOP:    top_q <= cfg_data;
					REG_BOTTOM: bottom_q <= cfg_data;
					REG_RADX:   radx_q <= cfg_data;
					REG_RADY:   rady_q <= cfg_data;
					default: ;
				endcase
				has_q <= '0; phas_q <= '0; inside_q <= '0;
				for (int k = 0; k < MaxFingers; k++) begin
					ax_q[k] <= '0; ay_q[k] <= '0;
				end
			end
			if (cmd.event_en) begin
				if (action == ACT_SLOT) begin
					if (!value[31] && value < 32'(MaxFingers)) active_q <= {1'b0, value[SlotW-1:0]};
					else active_q <= '1;
				end else if (!active_q[SlotW]) begin
					case (action)
						ACT_TRACK: begin
							tid_q[as] <= value; has_q[as] <= !value[31];
							dt_q[as] <= value[31] ? 48'd0 : timestamp_us; upd_q[as] <= 1'b1;
						end
						ACT_X: begin x_q[as] <= abs_sat16(value); upd_q[as] <= 1'b1; end
						ACT_Y: begin y_q[as] <= abs_sat16(value); upd_q[as] <= 1'b1; end
						ACT_MAJOR: begin maj_q[as] <= usat16(value); upd_q[as] <= 1'b1; end
						ACT_MINOR: begin min_q[as] <= usat16(value); upd_q[as] <= 1'b1; end
						ACT_ORIENT: begin ori_q[as] <= ssat16(value); upd_q[as] <= 1'b1; end
						ACT_TOOL: if (value == PALM_TOOL) begin has_q <= '0; upd_q <= '1; end
						default: ;
					endcase
				end
			end
			if (cmd.sync_start) begin
				count_q <= cnt_c;
				fts_q <= timestamp_us;
			end
			if (cmd.load_out) res <= pnd_q;
			if (cmd.slot_step) begin
				upd_q[s] <= 1'b0;
				phas_q[s] <= has; ptid_q[s] <= tid_q[s];
				px_q[s] <= x_q[s]; py_q[s] <= y_q[s];
				if (!inside_q[s]) begin
					if (small_in && has) inside_q[s] <= 1'b1;
				end else if (!has || !large_in) inside_q[s] <= 1'b0;
				if (st == ST_MOVE && (inside_q[s] || (mode_q[1] && !(small_in && has)))) begin
					ax_q[s] <= pass ? 18'sd0 : nax;
					ay_q[s] <= pass ? 18'sd0 : nay;
				end
				if (keep) begin
					pnd_q.slot_index <= 4'(s);
					pnd_q.touch_state <= st;
					pnd_q.pos_x <= has ? x_q[s] : '0;
					pnd_q.pos_y <= has ? y_q[s] : '0;
					pnd_q.touch_down_us <= has ? dt_q[s] : '0;
					pnd_q.contact_major <= has ? maj_q[s] : '0;
					pnd_q.contact_minor <= has ? min_q[s] : '0;
					pnd_q.contact_orientation <= has ? ori_q[s] : '0;
					pnd_q.finger_count <= count_q;
					pnd_q.frame_time_us <= fts_q;
				end
			end
		end
	end
endmodule

// ----- hw/rtl/mtref_ctrl.sv -----
// Controller: accepts beats, walks updated slots on a frame sync, holds results.
module mtref_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [3:0] action,
	input  logic detect_en,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic m_axis_tlast,
	output mtref_pkg::mtref_cmd_t cmd,
	input  mtref_pkg::mtref_sts_t sts,
	input  logic [mtref_pkg::MaxFingers-1:0] upd
);
	import mtref_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [SlotW-1:0] idx_q;
	logic pend_q; // a result sits in the datapath pending register, not yet shown
	logic acc, out_free, hit, stall, later;

	assign s_axis_tready = state_q == S_IDLE;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign hit = state_q == S_SCAN && upd[idx_q] && sts.emit;
	assign stall = hit && pend_q && !out_free;

	always_comb begin
		later = 1'b0;
		for (int k = 0; k < MaxFingers; k++)
			if (k > int'(idx_q) && upd[k]) later = 1'b1;
	end

	assign cmd.event_en = acc && detect_en && action != ACT_SYNC;
	assign cmd.sync_start = acc && detect_en && action == ACT_SYNC;
	assign cmd.slot_step = state_q == S_SCAN && upd[idx_q] && !stall;
	assign cmd.load_out = (hit && pend_q && !stall) || (state_q == S_FLUSH && out_free);
	assign cmd.slot_idx = idx_q;

	// A result is shown only once the next emitting slot (or scan end) is known,
	// so tlast is exact. The last pending one moves to the output in S_FLUSH.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; idx_q <= '0; pend_q <= 1'b0;
			m_axis_tvalid <= 1'b0; m_axis_tlast <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tlast <= state_q == S_FLUSH;
			end else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.sync_start) begin
					idx_q <= '0; state_q <= S_SCAN;
				end
				S_SCAN: if (!stall) begin
					if (hit) pend_q <= 1'b1;
					if (!later) state_q <= (pend_q || hit) ? S_FLUSH : S_IDLE;
					else idx_q <= idx_q + 1'b1;
				end
				S_FLUSH: if (out_free) begin
					pend_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/multitouch_region_event_filter_top.sv -----
// Top level: multitouch region event filter.
// Input channel s_axis carries one event per beat (action, value, timestamp).
// Output channel m_axis carries one report per reported slot; tlast marks the
// final report of a frame. Configuration goes through cfg_we/cfg_index/cfg_data,
// which the user must write only while idle (the block does not enforce this);
// every write to index 0 to 6 clears the slot contact state. Non-sync events
// can follow back to back. A frame sync walks the slots one per cycle, unless a
// stall holds the walk, up to the highest updated slot (at most ten), then enters
// the flush state if a report is pending; s_axis_tready is low until both are done.
// A report is held in a pending register until the next reporting slot or the
// end of the walk is known, so tlast is exact; the last report of a frame moves
// to m_axis in the flush state.
// Reset (arst_n low) clears all configuration and slot state, sets the active
// slot to invalid and empties the output. When the receiver stalls the report
// holds on m_axis; the walk goes on through non-reporting slots and pauses at
// the next reporting slot (or in the flush cycle) until the beat is taken.
module multitouch_region_event_filter_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [87:0] s_axis_tdata, // action[3:0], value[35:4], timestamp_us[83:36]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [191:0] m_axis_tdata, // slot_index, touch_state, pos_x, pos_y, down time,
	                                    // contact_major, contact_minor, contact_orientation,
	                                    // finger_count, frame_time_us (low bit up)
	output logic m_axis_tlast,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import mtref_pkg::*;

	mtref_cmd_t cmd;
	mtref_sts_t sts;
	mtref_res_t res;
	logic detect_en;
	logic [MaxFingers-1:0] upd;

	mtref_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.action(s_axis_tdata[3:0]), .value(s_axis_tdata[35:4]),
		.timestamp_us(s_axis_tdata[83:36]),
		.cmd, .sts, .detect_en, .upd, .res
	);

	mtref_ctrl u_ctrl (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .action(s_axis_tdata[3:0]),
		.detect_en, .m_axis_tvalid, .m_axis_tready, .m_axis_tlast, .cmd, .sts, .upd
	);

	assign m_axis_tdata = {6'd0, res.frame_time_us, res.finger_count,
		res.contact_orientation, res.contact_minor, res.contact_major,
		res.touch_down_us, res.pos_y, res.pos_x, res.touch_state, res.slot_index};
endmodule
